// ----- hw/rtl/bmp_stream_pixel_decoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// BMP stream pixel decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef BMP_STREAM_PIXEL_DECODER_CORE_DEFINES_SVH
`define BMP_STREAM_PIXEL_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define BMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bmp_pkg.sv -----
// ----------------------------------------------------------------------------
// BMP decoder package
// Status codes, depth codes, header constants and the queue entry type.
// ----------------------------------------------------------------------------
package bmp_pkg;

  typedef enum logic [2:0] {
    ST_PIXEL       = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_BAD_SIG     = 3'd2,
    ST_BAD_HDR     = 3'd3,
    ST_UNSUPPORTED = 3'd4,
    ST_TRUNCATED   = 3'd5
  } status_t;

  localparam logic [1:0] DEPTH_16 = 2'd0;
  localparam logic [1:0] DEPTH_24 = 2'd1;
  localparam logic [1:0] DEPTH_32 = 2'd2;

  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4d;
  localparam logic [32:0] FILE_HDR_LEN = 33'd14;
  localparam logic [31:0] HDR_CORE     = 32'd12;
  localparam logic [31:0] HDR_INFO     = 32'd40;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    status_t     status;
    logic        last;
    logic [23:0] raw;
    logic [7:0]  alpha;
    logic [1:0]  depth;
    logic [11:0] row;
    logic [11:0] col;
    logic [12:0] width;
    logic [12:0] height;
  } entry_t;

endpackage

// ----- hw/rtl/bmp_stream_pixel_decoder_core.sv -----
// ----------------------------------------------------------------------------
// BMP stream pixel decoder
// Decodes an uncompressed 16/24/32 bpp BMP byte stream into ABGR pixels
// tagged with destination row and column.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser  | tlast
//  s_      | in  | byte_value                             | -      | end_of_file
//  m_      | out | abgr, row, col, width, height          | status | is_last
//
//  One byte per cycle while s_tready is high; the front end handles each byte as it is accepted.
//  Results pass a two-entry queue and an output register.
//  s_tready falls only while the queue is full under output backpressure.
//  rst clears all parser state; end_of_file rearms the parser as well.
// ----------------------------------------------------------------------------
module bmp_stream_pixel_decoder_core
  import bmp_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // pixel_abgr, pixel_row, pixel_col, image_width, image_height
  output logic [2:0]  m_tuser,   // status
  output logic        m_tlast
);

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t q_entry;

  bmp_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_eof     (s_tlast),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  bmp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  bmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

// ----- hw/rtl/bmp_front.sv -----
// ----------------------------------------------------------------------------
// BMP decoder front end
// Parses header bytes, skips to the pixel data, gathers pixel bytes and
// drops row padding; emits one queue entry per result.
// ----------------------------------------------------------------------------
module bmp_front
  import bmp_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eof,
  input  logic       full,
  output logic       push,
  output entry_t     push_entry
);

  localparam int          DIM_W = $clog2(MAX_DIM + 1);
  localparam logic [31:0] MAX32 = 32'(MAX_DIM);

  localparam logic [31:0] POS_SIG0     = 32'd0;
  localparam logic [31:0] POS_SIG1     = 32'd1;
  localparam logic [31:0] POS_OFFSET   = 32'd13;
  localparam logic [31:0] POS_HDR_LEN  = 32'd17;
  localparam logic [31:0] POS_DIB      = 32'd18;
  localparam logic [31:0] POS_C_WIDTH  = 32'd19;
  localparam logic [31:0] POS_C_HEIGHT = 32'd21;
  localparam logic [31:0] POS_C_BPP    = 32'd25;
  localparam logic [31:0] POS_I_WIDTH  = 32'd21;
  localparam logic [31:0] POS_I_HEIGHT = 32'd25;
  localparam logic [31:0] POS_I_BPP    = 32'd29;
  localparam logic [31:0] POS_I_COMP   = 32'd33;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_PIXEL  = 5'b00100,
    PH_PAD    = 5'b01000,
    PH_DRAIN  = 5'b10000
  } phase_t;

  phase_t           phase, phase_next;
  logic [31:0]      pos, pos_next;
  logic [31:0]      offset, offset_next;
  logic             core, core_next;
  logic [DIM_W-1:0] width, width_next;
  logic [DIM_W-1:0] height, height_next;
  logic             top_down, top_down_next;
  logic [1:0]       depth, depth_next;
  logic [31:0]      fs, fs_next;
  logic [23:0]      pix, pix_next;
  logic [1:0]       bip, bip_next;
  logic [DIM_W-1:0] col, col_next;
  logic [DIM_W-1:0] row, row_next;
  logic [1:0]       pad, pad_next;

  logic        accept;
  logic [31:0] fs_new;
  logic [32:0] pos_inc;
  logic [15:0] v16;
  logic [16:0] mag17;
  logic [32:0] mag33;
  logic [15:0] bpp;
  logic [1:0]  bpp_code;
  logic        bpp_ok;
  logic        hdr_done;
  status_t     hst;
  logic [23:0] pix_or;
  logic [DIM_W:0] col_inc;
  logic [DIM_W:0] row_inc;
  logic [31:0] w32, wn32, hn32, c32, row32;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign fs_new   = {in_byte, fs[31:8]};
  assign pos_inc  = {1'b0, pos} + 33'd1;
  assign v16      = fs_new[31:16];
  assign w32      = 32'(width);
  assign c32      = 32'(col);

  always_comb begin
    bpp = core ? v16 : fs_new[31:16];
    bpp_ok = 1'b1;
    unique case (bpp)
      16'd16:  bpp_code = DEPTH_16;
      16'd24:  bpp_code = DEPTH_24;
      16'd32:  bpp_code = DEPTH_32;
      default: begin
        bpp_code = DEPTH_16;
        bpp_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_next    = phase;
    pos_next      = pos + 32'd1;
    offset_next   = offset;
    core_next     = core;
    width_next    = width;
    height_next   = height;
    top_down_next = top_down;
    depth_next    = depth;
    fs_next       = fs;
    pix_next      = pix;
    bip_next      = bip;
    col_next      = col;
    row_next      = row;
    pad_next      = pad;
    hst           = ST_PIXEL;
    hdr_done      = 1'b0;
    mag17         = {1'b0, v16};
    mag33         = {1'b0, fs_new};
    pix_or        = pix;
    col_inc       = {1'b0, col} + 1'b1;
    row_inc       = {1'b0, row} + 1'b1;
    row32         = 32'(height) - 32'd1 - 32'(row);
    push          = 1'b0;
    push_entry    = '0;

    unique case (phase)
      PH_HEADER: begin
        fs_next = fs_new;
        if (pos == POS_SIG0) begin
          if (in_byte != SIG_B) hst = ST_BAD_SIG;
        end else if (pos == POS_SIG1) begin
          if (in_byte != SIG_M) hst = ST_BAD_SIG;
        end else if (pos == POS_OFFSET) begin
          offset_next = fs_new;
        end else if (pos == POS_HDR_LEN) begin
          core_next = (fs_new == HDR_CORE);
          if (fs_new != HDR_CORE && fs_new < HDR_INFO) begin
            hst = ST_BAD_HDR;
          end else if ({1'b0, offset} < FILE_HDR_LEN + {1'b0, fs_new}) begin
            hst = ST_BAD_HDR;
          end
        end else if (pos >= POS_DIB) begin
          if (core) begin
            if (pos == POS_C_WIDTH) begin
              if ({16'd0, v16} > MAX32) hst = ST_BAD_HDR;
              else width_next = DIM_W'(v16);
            end else if (pos == POS_C_HEIGHT) begin
              if (v16[15]) begin
                mag17 = 17'h10000 - {1'b0, v16};
                top_down_next = 1'b1;
              end
              if ({15'd0, mag17} > MAX32) hst = ST_BAD_HDR;
              else height_next = DIM_W'(mag17);
            end else if (pos == POS_C_BPP) begin
              if (!bpp_ok) hst = ST_UNSUPPORTED;
              else begin
                depth_next = bpp_code;
                hdr_done = 1'b1;
              end
            end
          end else begin
            if (pos == POS_I_WIDTH) begin
              if (fs_new > MAX32) hst = ST_BAD_HDR;
              else width_next = DIM_W'(fs_new);
            end else if (pos == POS_I_HEIGHT) begin
              if (fs_new[31]) begin
                mag33 = 33'h1_0000_0000 - {1'b0, fs_new};
                top_down_next = 1'b1;
              end
              if (mag33 > {1'b0, MAX32}) hst = ST_BAD_HDR;
              else height_next = DIM_W'(mag33);
            end else if (pos == POS_I_BPP) begin
              if (!bpp_ok) hst = ST_UNSUPPORTED;
              else depth_next = bpp_code;
            end else if (pos == POS_I_COMP) begin
              if (fs_new != 32'd0) hst = ST_UNSUPPORTED;
              else hdr_done = 1'b1;
            end
          end
        end
        if (hdr_done) begin
          if (width == '0 || height == '0) hst = ST_EMPTY;
          else if (pos_inc == {1'b0, offset}) phase_next = PH_PIXEL;
          else phase_next = PH_SKIP;
        end
        if (hst != ST_PIXEL) begin
          push = 1'b1;
          push_entry.status = hst;
          push_entry.last = 1'b1;
          phase_next = PH_DRAIN;
        end
      end
      PH_SKIP: begin
        if (pos_inc >= {1'b0, offset}) phase_next = PH_PIXEL;
      end
      PH_PAD: begin
        pad_next = pad - 2'd1;
        if (pad_next == 2'd0) phase_next = PH_PIXEL;
      end
      PH_PIXEL: begin
        case (bip)
          2'd0:    pix_or = pix | {16'd0, in_byte};
          2'd1:    pix_or = pix | {8'd0, in_byte, 8'd0};
          2'd2:    pix_or = pix | {in_byte, 16'd0};
          default: pix_or = pix;
        endcase
        if ({1'b0, bip} < {1'b0, depth} + 3'd1) begin
          pix_next = pix_or;
          bip_next = bip + 2'd1;
        end else begin
          pix_next = '0;
          bip_next = '0;
          push = 1'b1;
          push_entry.status = ST_PIXEL;
          push_entry.raw = pix_or;
          push_entry.alpha = in_byte;
          push_entry.depth = depth;
          push_entry.row = top_down ? 12'(32'(row)) : row32[11:0];
          push_entry.col = c32[11:0];
          if (col_inc >= {1'b0, width}) begin
            col_next = '0;
            row_next = DIM_W'(row_inc);
            if (row_inc >= {1'b0, height}) begin
              push_entry.last = 1'b1;
              phase_next = PH_DRAIN;
            end else begin
              if (depth == DEPTH_16) pad_next = w32[0] ? 2'd2 : 2'd0;
              else if (depth == DEPTH_24) pad_next = w32[1:0];
              else pad_next = 2'd0;
              if (pad_next != 2'd0) phase_next = PH_PAD;
            end
          end else begin
            col_next = DIM_W'(col_inc);
          end
        end
      end
      PH_DRAIN: begin
        phase_next = PH_DRAIN;
      end
      default: begin
        phase_next = PH_DRAIN;
      end
    endcase

    wn32 = 32'(width_next);
    hn32 = 32'(height_next);
    push_entry.width  = wn32[12:0];
    push_entry.height = hn32[12:0];

    if (in_eof) begin
      if (phase_next != PH_DRAIN) begin
        push = 1'b1;
        push_entry.status = ST_TRUNCATED;
        push_entry.last = 1'b1;
        push_entry.raw = '0;
        push_entry.alpha = '0;
        push_entry.depth = '0;
        push_entry.row = '0;
        push_entry.col = '0;
      end
      phase_next    = PH_HEADER;
      pos_next      = '0;
      offset_next   = '0;
      core_next     = 1'b0;
      width_next    = '0;
      height_next   = '0;
      top_down_next = 1'b0;
      depth_next    = '0;
      fs_next       = '0;
      pix_next      = '0;
      bip_next      = '0;
      col_next      = '0;
      row_next      = '0;
      pad_next      = '0;
    end
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      pos      <= '0;
      offset   <= '0;
      core     <= 1'b0;
      width    <= '0;
      height   <= '0;
      top_down <= 1'b0;
      depth    <= '0;
      fs       <= '0;
      pix      <= '0;
      bip      <= '0;
      col      <= '0;
      row      <= '0;
      pad      <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      pos      <= pos_next;
      offset   <= offset_next;
      core     <= core_next;
      width    <= width_next;
      height   <= height_next;
      top_down <= top_down_next;
      depth    <= depth_next;
      fs       <= fs_next;
      pix      <= pix_next;
      bip      <= bip_next;
      col      <= col_next;
      row      <= row_next;
      pad      <= pad_next;
    end
  end

endmodule

// ----- hw/rtl/bmp_queue.sv -----
// ----------------------------------------------------------------------------
// BMP decoder result queue
// Two-entry queue of result entries between the front and back ends.
// ----------------------------------------------------------------------------
`include "bmp_stream_pixel_decoder_core_defines.svh"

module bmp_queue
  import bmp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t q_entry
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `BMP_ASSERT_NOW(a_push_room, push, !full, "entry pushed into full queue")
  `BMP_ASSERT_NOW(a_pop_data, pop, q_valid, "entry popped from empty queue")
  `BMP_ASSERT_NEXT(a_fill, push && !pop, count == $past(count) + 1'b1, "fill count slip")

endmodule

// ----- hw/rtl/bmp_back.sv -----
// ----------------------------------------------------------------------------
// BMP decoder back end
// Converts queued pixel bytes to ABGR and holds the result register.
// ----------------------------------------------------------------------------
module bmp_back
  import bmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [87:0] out_data,
  output logic [2:0]  out_user,
  output logic        out_last
);

  logic [31:0] abgr;
  logic [15:0] v;
  logic [7:0]  alpha;

  assign pop = q_valid && (!out_valid || out_ready);
  assign v   = q_entry.raw[15:0];

  always_comb begin
    alpha = (q_entry.depth == DEPTH_32) ? q_entry.alpha : ALPHA_OPAQUE;
    if (q_entry.status != ST_PIXEL) begin
      abgr = '0;
    end else if (q_entry.depth == DEPTH_16) begin
      abgr = {ALPHA_OPAQUE, v[4:0], 3'd0, v[9:5], 3'd0, v[14:10], 3'd0};
    end else begin
      abgr = {alpha, q_entry.raw[7:0], q_entry.raw[15:8], q_entry.raw[23:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {6'd0, q_entry.height, q_entry.width, q_entry.col, q_entry.row, abgr};
      out_user <= q_entry.status;
      out_last <= q_entry.last;
    end
  end

endmodule
